/* sv/apq_pkg.sv */
// Shared types, widths and codes for the array priority queue.
`timescale 1ns / 1ps

package apq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int TASK_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 2;

    typedef logic [TASK_W-1:0]   task_t;
    typedef logic [PRIO_W-1:0]   prio_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

/* sv/apq_req_if.sv */
// Request channel: one queue operation per transaction.
`timescale 1ns / 1ps

interface apq_req_if;

    logic          valid;
    logic          ready;
    logic          op;
    apq_pkg::task_t task_id;
    apq_pkg::prio_t prio;

    modport source (output valid, output op, output task_id, output prio, input ready);
    modport sink   (input valid, input op, input task_id, input prio, output ready);

endinterface

/* sv/apq_rsp_if.sv */
// Response channel: status and queue head after each operation.
`timescale 1ns / 1ps

interface apq_rsp_if;

    logic             valid;
    logic             ready;
    apq_pkg::status_t status;
    logic             is_empty;
    logic             is_full;
    apq_pkg::task_t   head_task;
    apq_pkg::prio_t   head_prio;

    modport source (output valid, output status, output is_empty, output is_full,
                    output head_task, output head_prio, input ready);
    modport sink   (input valid, input status, input is_empty, input is_full,
                    input head_task, input head_prio, output ready);

endinterface

/* sv/array_priority_queue.sv */
// Bounded priority queue of tasks held unsorted in arrival order, one memory port walked per cycle.
// Usage: each request transaction carries one operation. An insert appends the task at the
// tail (status full and no change when the queue holds DEPTH tasks). A remove takes out the
// highest-priority task, the earliest among equal priorities, and closes the gap so arrival
// order is kept (status empty on an empty queue). Every request yields one response with the
// status, the empty/full flags and the head task and priority afterwards (zero when empty).
// Operation: the entries sit in a memory with one registered read port, so every pass over
// them reads the entries one by one in address order. An insert writes the task at the tail
// (when not full) and then makes one scan for the new head; a remove from a non-empty queue
// makes one scan to find the head, a shift of the tail down one place, and a second scan for
// the new head.
// The request side is ready only between operations; a finished response waits in an output
// register and does not hold off the next request. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module array_priority_queue #(
    parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    apq_req_if.sink      req,
    apq_rsp_if.source    rsp
);

    import apq_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = ADDR_W + 1;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        DONE
    } state_t;

    // Entry store
    task_t mem_task [DEPTH];
    prio_t mem_prio [DEPTH];
    task_t rd_task_reg;
    prio_t rd_prio_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    task_t             wr_task;
    prio_t             wr_prio;
    logic [ADDR_W-1:0] rd_addr;

    // Sequencer and datapath registers
    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  occ_reg,       occ_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              rd_vld_reg,    rd_vld_next;
    logic [ADDR_W-1:0] rd_idx_reg,    rd_idx_next;
    logic              rm_pend_reg,   rm_pend_next;
    logic              found_reg,     found_next;
    logic [ADDR_W-1:0] best_idx_reg,  best_idx_next;
    task_t             best_task_reg, best_task_next;
    prio_t             best_prio_reg, best_prio_next;
    status_t           status_reg,    status_next;

    // Output register
    logic              out_valid_reg,  out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic              out_empty_reg,  out_empty_next;
    logic              out_full_reg,   out_full_next;
    task_t             out_task_reg,   out_task_next;
    prio_t             out_prio_reg,   out_prio_next;

    logic pass_end;

    assign req.ready     = (state_reg == IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.is_empty  = out_empty_reg;
    assign rsp.is_full   = out_full_reg;
    assign rsp.head_task = out_task_reg;
    assign rsp.head_prio = out_prio_reg;

    // A pass over the store is over once every read is issued and returned
    assign pass_end = (cnt_reg >= occ_reg) && !rd_vld_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_task[wr_addr] <= wr_task;
            mem_prio[wr_addr] <= wr_prio;
        end
        rd_task_reg <= mem_task[rd_addr];
        rd_prio_reg <= mem_prio[rd_addr];
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = cnt_reg[ADDR_W-1:0];
        rm_pend_next    = rm_pend_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_task_next  = best_task_reg;
        best_prio_next  = best_prio_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        out_task_next   = out_task_reg;
        out_prio_next   = out_prio_reg;
        rd_addr         = cnt_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = rd_idx_reg - ADDR_W'(1);
        wr_task         = rd_task_reg;
        wr_prio         = rd_prio_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    best_task_next = '0;
                    best_prio_next = '0;
                    rm_pend_next   = 1'b0;
                    status_next    = ST_DONE;
                    state_next     = SCAN;
                    if (req.op == OP_INSERT)
                    begin
                        if (occ_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = occ_reg[ADDR_W-1:0];
                            wr_task  = req.task_id;
                            wr_prio  = req.prio;
                            occ_next = occ_reg + CNT_W'(1);
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rm_pend_next = 1'b1;
                    end
                end
            end

            SCAN:
            begin
                // Issue one read per cycle, compare as data returns
                if (cnt_reg < occ_reg)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg && (!found_reg || (rd_prio_reg > best_prio_reg)))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_task_next = rd_task_reg;
                    best_prio_next = rd_prio_reg;
                end
                if (pass_end)
                begin
                    if (rm_pend_reg)
                    begin
                        rm_pend_next = 1'b0;
                        cnt_next     = CNT_W'(best_idx_reg) + CNT_W'(1);
                        state_next   = SHIFT;
                    end
                    else
                    begin
                        state_next = DONE;
                    end
                end
            end

            SHIFT:
            begin
                // Read entry k, write it back at k-1
                if (cnt_reg < occ_reg)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en = 1'b1;
                end
                if (pass_end)
                begin
                    occ_next       = occ_reg - CNT_W'(1);
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    best_task_next = '0;
                    best_prio_next = '0;
                    state_next     = SCAN;
                end
            end

            DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_empty_next  = (occ_reg == '0);
                    out_full_next   = (occ_reg == CNT_W'(DEPTH));
                    out_task_next   = best_task_reg;
                    out_prio_next   = best_prio_reg;
                    state_next      = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            rm_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_task_reg  <= '0;
            best_prio_reg  <= '0;
            status_reg     <= ST_DONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_empty_reg  <= 1'b1;
            out_full_reg   <= 1'b0;
            out_task_reg   <= '0;
            out_prio_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_idx_reg     <= rd_idx_next;
            rm_pend_reg    <= rm_pend_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_task_reg  <= best_task_next;
            best_prio_reg  <= best_prio_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_empty_reg  <= out_empty_next;
            out_full_reg   <= out_full_next;
            out_task_reg   <= out_task_next;
            out_prio_reg   <= out_prio_next;
        end
    end

endmodule

/* tb/sv/apq_checker.sv */
// Checker for the array priority queue: models the queue and compares every response.
`timescale 1ns / 1ps

module apq_checker #(
    parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    apq_req_if   req,
    apq_rsp_if   rsp,
    output int   errors,
    output int   outstanding
);

    import apq_pkg::*;

    // Queue state as seen from outside after one operation
    typedef struct packed {
        status_t status;
        logic    is_empty;
        logic    is_full;
        task_t   head_task;
        prio_t   head_prio;
    } queue_view_t;

    task_t       queue_task [DEPTH];
    prio_t       queue_prio [DEPTH];
    int          queue_len;
    queue_view_t expected_views [$];

    // Slot of the most urgent entry; strict compare keeps the earliest among ties
    function automatic int best_slot();
        int best;
        best = 0;
        for (int i = 1; i < queue_len; i++)
        begin
            if (queue_prio[i] > queue_prio[best])
                best = i;
        end
        return best;
    endfunction

    // Apply one operation to the modeled queue and return the view afterwards
    function automatic queue_view_t apply_request(logic op, task_t tid, prio_t pr);
        queue_view_t v;
        int          h;
        v.status = ST_DONE;
        if (op == OP_INSERT)
        begin
            if (queue_len >= DEPTH)
                v.status = ST_FULL;
            else
            begin
                queue_task[queue_len] = tid;
                queue_prio[queue_len] = pr;
                queue_len++;
            end
        end
        else if (queue_len == 0)
            v.status = ST_EMPTY;
        else
        begin
            // close the gap, keeping arrival order
            for (int i = best_slot(); i + 1 < queue_len; i++)
            begin
                queue_task[i] = queue_task[i + 1];
                queue_prio[i] = queue_prio[i + 1];
            end
            queue_len--;
        end
        v.is_empty  = (queue_len == 0);
        v.is_full   = (queue_len >= DEPTH);
        v.head_task = '0;
        v.head_prio = '0;
        if (queue_len > 0)
        begin
            h           = best_slot();
            v.head_task = queue_task[h];
            v.head_prio = queue_prio[h];
        end
        return v;
    endfunction

    initial
    begin
        errors      = 0;
        outstanding = 0;
        queue_len   = 0;
    end

    // Responses are compared before the same edge's request is modeled
    always @(posedge clk)
    begin
        queue_view_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0b, actual %0b",
                               want.is_empty, rsp.is_empty);
                        errors++;
                    end
                    if (rsp.is_full !== want.is_full)
                    begin
                        $error("is_full: expected %0b, actual %0b", want.is_full, rsp.is_full);
                        errors++;
                    end
                    if (rsp.head_task !== want.head_task)
                    begin
                        $error("head_task: expected %h, actual %h",
                               want.head_task, rsp.head_task);
                        errors++;
                    end
                    if (rsp.head_prio !== want.head_prio)
                    begin
                        $error("head_prio: expected %h, actual %h",
                               want.head_prio, rsp.head_prio);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_views.push_back(apply_request(req.op, req.task_id, req.prio));
            outstanding = expected_views.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the array priority queue: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module tb;

    import apq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1530;
    localparam int CALM_ITEMS   = 150;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   idle_pct;
    int   stall_left;

    apq_req_if req_ch ();
    apq_rsp_if rsp_ch ();

    array_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    apq_checker #(.DEPTH(DEPTH)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #8000000;
        $display("array_priority_queue test failed");
        $finish;
    end

    // Response side: random stall bursts on ready
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Drive one request transaction and wait for it to be taken
    task automatic send(logic op, task_t tid, prio_t pr);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.task_id <= tid;
        req_ch.prio    <= pr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic prio_t pick_prio();
        case ($urandom_range(0, 3))
            0:       return prio_t'($urandom_range(0, 3));   // dense ties
            1:       return $urandom_range(0, 1) ? '1 : '0;  // extremes
            default: return prio_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int insert_pct;
        int run_left;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_INSERT;
        req_ch.task_id = '0;
        req_ch.prio    = '0;
        rsp_ch.ready   = 1'b0;
        idle_pct       = 0;
        stall_left     = 0;
        rst_n          = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty remove, extremes, ties, fill to full, insert when full
        send(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_INSERT, 32'h0000_0000, 16'h0000);
        send(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_INSERT, 32'hAAAA_5555, 16'hFFFF);
        send(OP_INSERT, 32'h1234_5678, 16'h0000);
        send(OP_REMOVE, 32'h0, 16'h0);
        send(OP_REMOVE, 32'h0, 16'h0);
        for (int k = 0; k < DEPTH - 2; k++)
            send(OP_INSERT, $urandom, prio_t'(k * 4681));
        send(OP_INSERT, 32'h5555_AAAA, 16'hFFFF);

        // Random runs with shifting insert bias so occupancy sweeps empty to full
        insert_pct = 50;
        run_left   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(32, 64);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            run_left--;
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                idle_pct = 0;
            // drain the pipeline once mid-run
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                wait (outstanding == 0);
            end
            if ($urandom_range(0, 99) < insert_pct)
                send(OP_INSERT, $urandom, pick_prio());
            else
                send(OP_REMOVE, $urandom, prio_t'($urandom));
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("array_priority_queue test passed");
        else
            $display("array_priority_queue test failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/apq_pkg.sv
sv/apq_req_if.sv
sv/apq_rsp_if.sv
sv/array_priority_queue.sv
tb/sv/apq_checker.sv
tb/sv/tb.sv
